>>> rtl/teq_pkg.sv
// ---------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the time-ordered event queue: request and
// status codes, the stored entry layout, and the controller/datapath bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package teq_pkg;

    localparam int TEQ_DEFAULT_DEPTH = 16;

    // request codes
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_EDIT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // walk index operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_COUNT = 3'd2;
    localparam logic [2:0] IDX_INC   = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;

    // read address relative to the next walk index
    localparam logic [1:0] RD_SAME = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // packed so that a plain unsigned compare is lexicographic
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } evt_time_t;

    typedef struct packed {
        logic [15:0] tag;
        evt_time_t   tm;
    } entry_t;

    typedef struct packed {
        logic       capture;     // latch request fields, clear result
        logic       set_status;
        logic [1:0] status_code;
        logic       pop_load;    // latch the read entry as pop result
        logic [2:0] idx_op;
        logic [1:0] rd_mode;
        logic       wr_en;
        logic       wr_new;      // write the new entry instead of the read one
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic idx_last1;         // idx + 1 == count
        logic idx_last2;         // idx + 2 == count
        logic time_ge;           // read entry time >= new entry time
        logic tag_match;
    } sts_t;

endpackage

>>> rtl/teq_dpath.sv
// ---------------------------------------------------------------------------
// teq_dpath
// Entry memory with one write and one registered read port, walk index,
// fill count, request holding registers and the result/output registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module teq_dpath #(
    parameter int QUEUE_DEPTH = teq_pkg::TEQ_DEFAULT_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  teq_pkg::cmd_t cmd,
    output teq_pkg::sts_t sts,
    input  logic [1:0]    req_type,
    input  logic [15:0]   event_tag,
    input  logic [15:0]   new_tag,
    input  logic [4:0]    hour,
    input  logic [5:0]    minute,
    input  logic [5:0]    second,
    output logic [1:0]    status,
    output logic [15:0]   out_tag,
    output logic [4:0]    out_hour,
    output logic [5:0]    out_minute,
    output logic [5:0]    out_second,
    output logic [4:0]    occupancy
);
    import teq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t          entry_mem_reg [QUEUE_DEPTH];
    entry_t          rd_entry_reg;
    entry_t          ins_entry_reg;
    logic [15:0]     key_tag_reg;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW:0]     idx_ext;
    logic [CW:0]     cnt_ext;
    logic [1:0]      res_status_reg;
    entry_t          res_entry_reg;
    logic [1:0]      out_status_reg;
    entry_t          out_entry_reg;
    logic [CW+4:0]   occ_ext;
    logic [4:0]      out_occ_reg;

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_COUNT: idx_next = count_reg[AW-1:0];
            IDX_INC:   idx_next = idx_reg + AW'(1);
            IDX_DEC:   idx_next = idx_reg - AW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_mode)
            RD_PREV: rd_addr = idx_next - AW'(1);
            RD_NEXT: rd_addr = idx_next + AW'(1);
            default: rd_addr = idx_next;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // entry memory: write at the walk index, read at, before or after the next walk index
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entry_mem_reg[idx_reg] <= cmd.wr_new ? ins_entry_reg : rd_entry_reg;
        end
        rd_entry_reg <= entry_mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // request and result holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_tag_reg          <= event_tag;
            ins_entry_reg.tag    <= (req_type == REQ_EDIT) ? new_tag : event_tag;
            ins_entry_reg.tm     <= '{hour: hour, minute: minute, second: second};
            res_status_reg       <= cmd.status_code;
            res_entry_reg        <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.pop_load)
            begin
                res_entry_reg <= rd_entry_reg;
            end
        end
    end

    assign occ_ext = {{5{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_occ_reg    <= occ_ext[4:0];
        end
    end

    assign idx_ext = (CW+1)'(idx_reg);
    assign cnt_ext = {1'b0, count_reg};

    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.cnt_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_last1 = ((idx_ext + (CW+1)'(1)) == cnt_ext);
    assign sts.idx_last2 = ((idx_ext + (CW+1)'(2)) == cnt_ext);
    assign sts.time_ge   = (rd_entry_reg.tm >= ins_entry_reg.tm);
    assign sts.tag_match = (rd_entry_reg.tag == key_tag_reg);

    assign status     = out_status_reg;
    assign out_tag    = out_entry_reg.tag;
    assign out_hour   = out_entry_reg.tm.hour;
    assign out_minute = out_entry_reg.tm.minute;
    assign out_second = out_entry_reg.tm.second;
    assign occupancy  = out_occ_reg;

endmodule

>>> rtl/teq_ctrl.sv
// ---------------------------------------------------------------------------
// teq_ctrl
// Request sequencer: dispatches add, pop and edit, steps the search, remove
// and insert walks over the entry memory, and owns both handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module teq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    req_type,
    output logic          out_valid,
    input  logic          out_stall,
    output teq_pkg::cmd_t cmd,
    input  teq_pkg::sts_t sts
);
    import teq_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_START = 3'd1;
    localparam logic [2:0] S_INS_WALK  = 3'd2;
    localparam logic [2:0] S_POP_CAP   = 3'd3;
    localparam logic [2:0] S_SCAN      = 3'd4;
    localparam logic [2:0] S_RM_WALK   = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_edit_reg;
    logic       is_edit_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        is_edit_next   = is_edit_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture     = 1'b1;
                    cmd.status_code = ST_OK;
                    is_edit_next    = (req_type == REQ_EDIT);
                    case (req_type)
                        REQ_ADD:
                        begin
                            if (sts.cnt_full)
                            begin
                                cmd.status_code = ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                // start at the tail, read the last entry
                                cmd.idx_op  = IDX_COUNT;
                                cmd.rd_mode = RD_PREV;
                                state_next  = S_INS_WALK;
                            end
                        end
                        REQ_POP:
                        begin
                            if (sts.cnt_zero)
                            begin
                                cmd.status_code = ST_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                cmd.idx_op  = IDX_ZERO;
                                cmd.rd_mode = RD_SAME;
                                state_next  = S_POP_CAP;
                            end
                        end
                        REQ_EDIT:
                        begin
                            if (sts.cnt_zero)
                            begin
                                cmd.status_code = ST_NOTFOUND;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                cmd.idx_op  = IDX_ZERO;
                                cmd.rd_mode = RD_SAME;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_INS_START:
            begin
                cmd.idx_op  = IDX_COUNT;
                cmd.rd_mode = RD_PREV;
                state_next  = S_INS_WALK;
            end

            S_INS_WALK:
            begin
                cmd.wr_en = 1'b1;
                if (!sts.idx_zero && sts.time_ge)
                begin
                    // move the entry one place toward the tail
                    cmd.idx_op  = IDX_DEC;
                    cmd.rd_mode = RD_PREV;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end

            S_POP_CAP:
            begin
                cmd.pop_load = 1'b1;
                if (sts.idx_last1)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_mode = RD_NEXT;
                    state_next  = S_RM_WALK;
                end
            end

            S_SCAN:
            begin
                if (sts.tag_match)
                begin
                    if (sts.idx_last1)
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_INS_START;
                    end
                    else
                    begin
                        cmd.rd_mode = RD_NEXT;
                        state_next  = S_RM_WALK;
                    end
                end
                else if (sts.idx_last1)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOTFOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.idx_op  = IDX_INC;
                    cmd.rd_mode = RD_SAME;
                end
            end

            S_RM_WALK:
            begin
                // close the gap: pull the next entry one place toward the head
                cmd.wr_en = 1'b1;
                if (sts.idx_last2)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = is_edit_reg ? S_INS_START : S_FINISH;
                end
                else
                begin
                    cmd.idx_op  = IDX_INC;
                    cmd.rd_mode = RD_NEXT;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (!accept)
        begin
            cmd.capture = cmd.capture && accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_edit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_edit_reg   <= is_edit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/time_ordered_event_queue.sv
// ---------------------------------------------------------------------------
// time_ordered_event_queue
// Sorted queue of timed events (hour, minute, second), earliest at the head.
// Add, pop and edit-by-tag requests; one result transaction per request.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   in_valid / in_stall  req_type, event_tag, new_tag, hour,
//                                 minute, second
//  result    out_valid/out_stall  status, out_tag, out_hour, out_minute,
//                                 out_second, occupancy
//
//  One request at a time. The add, pop and edit requests walk over the
//  entry memory one entry a cycle, through its write and registered read
//  ports. Reset clears the fill count, walk index, sequencer state and
//  handshakes only; no clearing pass.
//  A new request is taken while the previous result still waits on
//  out_stall; the sequencer holds at its last step until the output frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_ordered_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::TEQ_DEFAULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] event_tag,
    input  logic [15:0] new_tag,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] out_tag,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [5:0]  out_second,
    output logic [4:0]  occupancy
);
    import teq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    teq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    teq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .event_tag  (event_tag),
        .new_tag    (new_tag),
        .hour       (hour),
        .minute     (minute),
        .second     (second),
        .status     (status),
        .out_tag    (out_tag),
        .out_hour   (out_hour),
        .out_minute (out_minute),
        .out_second (out_second),
        .occupancy  (occupancy)
    );

endmodule
